FILE: hdl/cdc_pkg.sv
// Package for the content-defined chunker: payload types, sizes, register codes, gear table.
package cdc_pkg;

   localparam int GEAR_ENTRIES = 256;
   localparam int SIZE_BITS    = 24;
   localparam int OFFSET_BITS  = 48;
   localparam int REG_W        = SIZE_BITS + 1;
   localparam int LG_W         = $clog2(REG_W);
   localparam int MASK_W       = 32;   // masks only cover hash bits 63:32
   localparam int HASH_W       = 64;
   localparam int GEAR_IDX_W   = $clog2(GEAR_ENTRIES);
   localparam int CSR_IDX_W    = 2;

   localparam logic [REG_W-1:0] MIN_RESET = REG_W'(16384);
   localparam logic [REG_W-1:0] AVG_RESET = REG_W'(65536);
   localparam logic [REG_W-1:0] MAX_RESET = REG_W'(262144);

   localparam logic [HASH_W-1:0] GEAR_SEED = 64'h9e3779b97f4a7c15;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_SIZE = 2'd0,
      CSR_AVG_SIZE = 2'd1,
      CSR_MAX_SIZE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [47:0] boundary_offset;
      logic        end_of_stream;
      logic        last_of_run;
      logic        status;
   } rsp_type;

   typedef struct packed {
      logic [MASK_W-1:0] strict_mask;
      logic [MASK_W-1:0] loose_mask;
      logic              loose_all;    // loose mask covers the whole hash
   } mask_type;

   typedef logic [HASH_W-1:0] gear_rom_type [GEAR_ENTRIES];

   // xorshift64 sequence; entry i is the state after i+1 rounds
   function automatic gear_rom_type gen_gear();
      gear_rom_type t;
      logic [HASH_W-1:0] s;
      s = GEAR_SEED;
      for (int i = 0; i < GEAR_ENTRIES; i++) begin
         s = s ^ (s << 13);
         s = s ^ (s >> 7);
         s = s ^ (s << 17);
         t[i] = s;
      end
      return t;
   endfunction

   localparam gear_rom_type GEAR_ROM = gen_gear();

   // masks from floor(log2(avg)); avg of zero acts as log 0
   function automatic mask_type avg_masks(logic [REG_W-1:0] avg);
      mask_type m;
      logic [LG_W-1:0] lg;
      lg = '0;
      for (int i = 0; i < REG_W; i++) begin
         if (avg[i]) begin
            lg = LG_W'(i);
         end
      end
      for (int i = 0; i < MASK_W; i++) begin
         m.strict_mask[i] = (i <= int'(lg));
         m.loose_mask[i]  = (i + 1 < int'(lg));
      end
      m.loose_all = (lg == '0);
      return m;
   endfunction

   localparam mask_type MASK_RESET = avg_masks(AVG_RESET);

endpackage

FILE: hdl/content_defined_chunker.sv
// Content-defined chunker top level: gear-hash cut detection and boundary output queue.
//
//  channel | ports                          | beat
//  --------+--------------------------------+------------------------------------------
//  input   | req_valid/req_ready/req_data   | one stream byte, final flag
//  output  | rsp_valid/rsp_ready/rsp_data   | one boundary offset with flags and status
//  config  | csr_we/csr_index/csr_wdata     | one size register write, no wait
//
// One byte per cycle while the output queue has room. A byte is taken into the input
// register (its gear entry is looked up there), then the hash update and cut test write
// zero, one or two beats into a four-beat output queue, whose registers hold the beats.
// A byte that causes two beats (cut plus end of stream) writes both at once; they leave one by one.
// The processing step waits while the queue holds more than two beats; rsp_ready
// low thus backs up into req_ready. Synchronous reset clears state and queue and
// loads the default sizes; no clearing pass is needed.
module content_defined_chunker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  cdc_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output cdc_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [cdc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cdc_pkg::REG_W-1:0]     csr_wdata
);
   import cdc_pkg::*;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = Q_PTR_W + 1;

   // configuration registers; masks are derived when avg_size is written
   logic [REG_W-1:0] min_size_ff, avg_size_ff, max_size_ff;
   mask_type         mask_ff;

   // input register: gear entry already looked up
   logic              in_valid_ff;
   logic [HASH_W-1:0] in_gear_ff;
   logic              in_final_ff;

   // chunking state
   logic [HASH_W-1:0]      hash_ff, hash_in;
   logic [REG_W-1:0]       chunk_ff, chunk_in;
   logic [OFFSET_BITS-1:0] stream_ff, stream_in;

   // output queue
   rsp_type            q_mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] q_wr_ff, q_rd_ff;
   logic [Q_CNT_W-1:0] q_cnt_ff;

   logic                   proc;
   logic                   cfg_bad;
   logic                   force_cut, hashing, hit, cut;
   logic [REG_W-1:0]       c1, c2;
   logic [HASH_W-1:0]      h1, hn;
   logic                   below_avg, mask_zero;
   logic [OFFSET_BITS-1:0] stream_inc;
   logic                   push_a, push_b;
   rsp_type                beat_a, beat_b;
   logic                   pop;
   logic [Q_CNT_W-1:0]     push_n;
   logic [Q_PTR_W-1:0]     q_wr_in;
   logic [Q_CNT_W-1:0]     q_cnt_in;

   // process when the queue can take two more beats
   assign proc      = in_valid_ff && (q_cnt_ff <= Q_CNT_W'(Q_DEPTH - 2));
   assign req_ready = !in_valid_ff || proc;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (q_cnt_ff != '0);
   assign rsp_data  = q_mem_ff[q_rd_ff];

   assign cfg_bad = (min_size_ff == '0) || (avg_size_ff < min_size_ff) ||
                    (max_size_ff < avg_size_ff);

   always_comb begin
      // chunk full (or sizes shrunk mid-chunk): cut before this byte
      force_cut = (chunk_ff >= max_size_ff);
      c1        = force_cut ? '0 : chunk_ff;
      h1        = force_cut ? '0 : hash_ff;
      hashing   = (c1 >= min_size_ff);
      hn        = {h1[HASH_W-2:0], 1'b0} + in_gear_ff;
      below_avg = (c1 < avg_size_ff);
      if (below_avg) begin
         mask_zero = ((hn[HASH_W-1:HASH_W-MASK_W] & mask_ff.strict_mask) == '0);
      end else if (mask_ff.loose_all) begin
         mask_zero = (hn == '0);
      end else begin
         mask_zero = ((hn[HASH_W-1:HASH_W-MASK_W] & mask_ff.loose_mask) == '0);
      end
      hit        = hashing && mask_zero;
      cut        = force_cut || hit;
      c2         = hit ? '0 : c1;
      stream_inc = stream_ff + OFFSET_BITS'(1);

      hash_in   = hash_ff;
      chunk_in  = chunk_ff;
      stream_in = stream_ff;
      push_a    = 1'b0;
      push_b    = 1'b0;

      beat_a.boundary_offset = 48'(stream_ff);
      beat_a.end_of_stream   = 1'b0;
      beat_a.last_of_run     = !in_final_ff;
      beat_a.status          = 1'b0;
      beat_b.boundary_offset = 48'(stream_inc);
      beat_b.end_of_stream   = 1'b1;
      beat_b.last_of_run     = 1'b1;
      beat_b.status          = 1'b0;

      if (proc) begin
         if (cfg_bad) begin
            // error beat, stream restarts
            hash_in   = '0;
            chunk_in  = '0;
            stream_in = '0;
            push_a    = 1'b1;
            beat_a.boundary_offset = '0;
            beat_a.end_of_stream   = in_final_ff;
            beat_a.last_of_run     = 1'b1;
            beat_a.status          = 1'b1;
         end else if (in_final_ff) begin
            hash_in   = '0;
            chunk_in  = '0;
            stream_in = '0;
            push_a    = cut;
            push_b    = 1'b1;
         end else begin
            hash_in   = hit ? '0 : (hashing ? hn : h1);
            chunk_in  = c2 + REG_W'(1);
            stream_in = stream_inc;
            push_a    = cut;
         end
      end

      push_n   = Q_CNT_W'(push_a) + Q_CNT_W'(push_b);
      q_wr_in  = q_wr_ff + Q_PTR_W'(push_n);
      q_cnt_in = q_cnt_ff + push_n - Q_CNT_W'(pop);
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_size_ff <= MIN_RESET;
         avg_size_ff <= AVG_RESET;
         max_size_ff <= MAX_RESET;
         mask_ff     <= MASK_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_SIZE: min_size_ff <= csr_wdata;
            CSR_AVG_SIZE: begin
               avg_size_ff <= csr_wdata;
               mask_ff     <= avg_masks(csr_wdata);
            end
            CSR_MAX_SIZE: max_size_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register with gear lookup
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_gear_ff  <= GEAR_ROM[req_data.data_byte];
         in_final_ff <= req_data.final_byte;
      end
   end

   // chunking state
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff   <= '0;
         chunk_ff  <= '0;
         stream_ff <= '0;
      end else begin
         hash_ff   <= hash_in;
         chunk_ff  <= chunk_in;
         stream_ff <= stream_in;
      end
   end

   // output queue: beat A goes first, beat B after it
   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         q_wr_ff  <= q_wr_in;
         q_cnt_ff <= q_cnt_in;
         if (pop) begin
            q_rd_ff <= q_rd_ff + Q_PTR_W'(1);
         end
      end
      if (push_a) begin
         q_mem_ff[q_wr_ff] <= beat_a;
      end
      if (push_b) begin
         q_mem_ff[q_wr_ff + Q_PTR_W'(push_a)] <= beat_b;
      end
   end

endmodule
